// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/core/mqpfi_pkg.sv =====
package mqpfi_pkg;

  localparam int QIDX_W    = 4;
  localparam int ID_IN_W   = 16;
  localparam int CNT_OUT_W = 4;
  localparam int STAT_W    = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/mqpfi_if.sv =====
interface mqpfi_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  queue_index;
  logic [15:0] entry_id;
  logic        urgent;

  modport source (output valid, mode, queue_index, entry_id, urgent, input ready);
  modport sink (input valid, mode, queue_index, entry_id, urgent, output ready);
endinterface

interface mqpfi_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_id;
  logic [3:0]  queue_count;

  modport source (output valid, status, served_id, queue_count, input ready);
  modport sink (input valid, status, served_id, queue_count, output ready);
endinterface

// ===== rtl/core/multi_queue_priority_front_insert_top.sv =====
// Bank of bounded double-ended queues sharing one entry RAM. An enqueue beat
// puts an id at the back of the named queue, or at the front when urgent is
// set; a dequeue beat pops the front entry. Every request beat yields one
// result beat with a status, the popped id and the new count. On accept,
// the request reads the queue's front pointer and count registers and issues
// the single entry RAM access; then, in the fetch state and once the result
// slot is free, the registered RAM read data moves into the output register.
// A new request is taken only after that load, so requests never overlap and
// a stalled result side holds off the next request. The entry RAM needs no
// clearing after reset.
`include "assert_macros.svh"
module multi_queue_priority_front_insert_top #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  mqpfi_in_if.sink           in_ch,
  mqpfi_out_if.source        out_ch
);
  import mqpfi_pkg::*;

  ctrl_cmd_t cmd;

  mqpfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  mqpfi_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .mode        (in_ch.mode),
    .queue_index (in_ch.queue_index),
    .entry_id    (in_ch.entry_id),
    .urgent      (in_ch.urgent),
    .status      (out_ch.status),
    .served_id   (out_ch.served_id),
    .queue_count (out_ch.queue_count)
  );

  // one request in flight at a time
  `ASSERT_CLK(a_one_in_flight, in_ch.valid && in_ch.ready |=> !in_ch.ready)
  // only a dequeue returns an id
  `ASSERT_NEVER(a_id_only_on_deq, out_ch.valid && out_ch.status != ST_DEQ && out_ch.served_id != '0)
  // an empty answer reports no entries
  `ASSERT_CLK(a_empty_count, out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.queue_count == '0)

endmodule

// ===== rtl/core/mqpfi_ram.sv =====
module mqpfi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mqpfi_ctrl.sv =====
module mqpfi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output mqpfi_pkg::ctrl_cmd_t  cmd
);
  import mqpfi_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        // result slot free once the waiting beat leaves
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/mqpfi_dp.sv =====
module mqpfi_dp #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mqpfi_pkg::ctrl_cmd_t                     cmd,
  input  logic                                     mode,
  input  logic [mqpfi_pkg::QIDX_W-1:0]             queue_index,
  input  logic [mqpfi_pkg::ID_IN_W-1:0]            entry_id,
  input  logic                                     urgent,
  output logic [mqpfi_pkg::STAT_W-1:0]             status,
  output logic [mqpfi_pkg::ID_IN_W-1:0]            served_id,
  output logic [mqpfi_pkg::CNT_OUT_W-1:0]          queue_count
);
  import mqpfi_pkg::*;

  localparam int NQ    = (NUM_QUEUES < 2**QIDX_W) ? NUM_QUEUES : 2**QIDX_W;
  localparam int QW    = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = (ID_WIDTH < ID_IN_W) ? ID_WIDTH : ID_IN_W;
  localparam int SLOTS = NQ * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [CW-1:0]   DEPTH_C  = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]   LAST_P   = PW'(QUEUE_DEPTH - 1);
  localparam logic [PW+1:0]   DEPTH_S  = (PW + 2)'(QUEUE_DEPTH);
  localparam logic [QIDX_W:0] NQ_C     = (QIDX_W + 1)'(NQ);
  localparam logic [AW-1:0]   DEPTH_A  = AW'(QUEUE_DEPTH);

  logic [PW-1:0] front_r [NQ];
  logic [CW-1:0] count_r [NQ];

  logic [QW-1:0] qsel;
  logic          in_range, is_enq, full, empty, enq_ok, deq_ok;
  logic [PW-1:0] cur_front, front_dec, front_inc, back_slot, slot;
  logic [CW-1:0] cur_cnt, new_cnt;
  logic [PW+1:0] back_sum;
  logic [AW-1:0] ram_addr;
  logic [SW-1:0] ram_rdata;
  status_t       res_status;

  status_t                pend_status_r;
  logic [CNT_OUT_W-1:0]   pend_cnt_r;
  logic                   pend_deq_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [ID_IN_W-1:0]     out_served_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;

  assign qsel      = queue_index[QW-1:0];
  assign in_range  = {1'b0, queue_index} < NQ_C;
  assign is_enq    = (mode == MODE_ENQ);
  assign cur_front = front_r[qsel];
  assign cur_cnt   = count_r[qsel];
  assign full      = (cur_cnt == DEPTH_C);
  assign empty     = (cur_cnt == '0);
  assign enq_ok    = in_range && is_enq && !full;
  assign deq_ok    = in_range && !is_enq && !empty;

  assign front_dec = (cur_front == '0) ? LAST_P : cur_front - 1'b1;
  assign front_inc = (cur_front == LAST_P) ? '0 : cur_front + 1'b1;
  assign back_sum  = (PW + 2)'(cur_front) + (PW + 2)'(cur_cnt);
  assign back_slot = (back_sum >= DEPTH_S) ? PW'(back_sum - DEPTH_S) : PW'(back_sum);
  assign slot      = is_enq ? (urgent ? front_dec : back_slot) : cur_front;
  assign ram_addr  = AW'(qsel) * DEPTH_A + AW'(slot);

  always_comb begin
    res_status = ST_ENQ;
    new_cnt    = '0;
    if (!in_range) begin
      res_status = is_enq ? ST_FULL : ST_EMPTY;
    end else if (is_enq) begin
      res_status = full ? ST_FULL : ST_ENQ;
      new_cnt    = full ? cur_cnt : cur_cnt + 1'b1;
    end else begin
      res_status = empty ? ST_EMPTY : ST_DEQ;
      new_cnt    = empty ? '0 : cur_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        front_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.accept) begin
      if (enq_ok) begin
        count_r[qsel] <= new_cnt;
        if (urgent) begin
          front_r[qsel] <= front_dec;
        end
      end else if (deq_ok) begin
        count_r[qsel] <= new_cnt;
        front_r[qsel] <= front_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status_r <= res_status;
      pend_cnt_r    <= CNT_OUT_W'(new_cnt);
      pend_deq_r    <= deq_ok;
    end
    if (cmd.load) begin
      out_status_r <= pend_status_r;
      out_served_r <= pend_deq_r ? ID_IN_W'(ram_rdata) : '0;
      out_cnt_r    <= pend_cnt_r;
    end
  end

  mqpfi_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.accept && enq_ok),
    .re    (cmd.accept && deq_ok),
    .addr  (ram_addr),
    .wdata (SW'(entry_id)),
    .rdata (ram_rdata)
  );

  assign status      = out_status_r;
  assign served_id   = out_served_r;
  assign queue_count = out_cnt_r;

endmodule
